[rtl/tfatc_pkg.sv]
// ----------------------------------------------------------------------------
// tfatc_pkg
// Shared types and constants of the two-fan airflow threshold controller.
// ----------------------------------------------------------------------------
package tfatc_pkg;

    // trigger reason codes
    typedef enum logic [2:0] {
        RSN_NONE   = 3'd0,
        RSN_TEMP   = 3'd1,
        RSN_HUMID  = 3'd2,
        RSN_VPD    = 3'd3,
        RSN_MANUAL = 3'd4
    } reason_t;

    // transaction mode codes
    localparam logic MODE_EVAL     = 1'b0;
    localparam logic MODE_OVERRIDE = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_TEMP_EXTREME   = 3'd0;
    localparam logic [2:0] CFG_TEMP_STAGE_ONE = 3'd1;
    localparam logic [2:0] CFG_TEMP_CLEAR     = 3'd2;
    localparam logic [2:0] CFG_HUMID_HIGH     = 3'd3;
    localparam logic [2:0] CFG_HUMID_CLEAR    = 3'd4;
    localparam logic [2:0] CFG_VPD_LOW        = 3'd5;
    localparam logic [2:0] CFG_VPD_OK         = 3'd6;
    localparam logic [2:0] CFG_MIN_CYCLE_MS   = 3'd7;

    // configuration register reset values
    localparam logic signed [14:0] TEMP_EXTREME_RST   = 15'sd3500;
    localparam logic signed [14:0] TEMP_STAGE_ONE_RST = 15'sd2900;
    localparam logic signed [14:0] TEMP_CLEAR_RST     = 15'sd2800;
    localparam logic [13:0]        HUMID_HIGH_RST     = 14'd8500;
    localparam logic [13:0]        HUMID_CLEAR_RST    = 14'd8000;
    localparam logic [13:0]        VPD_LOW_RST        = 14'd650;
    localparam logic [13:0]        VPD_OK_RST         = 14'd800;
    localparam logic [31:0]        MIN_CYCLE_MS_RST   = 32'd30000;

    typedef struct packed {
        logic signed [14:0] temp_extreme;
        logic signed [14:0] temp_stage_one;
        logic signed [14:0] temp_clear;
        logic [13:0]        humid_high;
        logic [13:0]        humid_clear;
        logic [13:0]        vpd_low;
        logic [13:0]        vpd_ok;
        logic [31:0]        min_cycle_ms;
    } cfg_t;

    typedef struct packed {
        logic               mode;
        logic signed [14:0] temperature;
        logic [13:0]        humidity;
        logic [13:0]        vpd;
        logic [31:0]        now_ms;
        logic               override_enable;
        logic               override_fan_one;
        logic               override_fan_two;
    } item_t;

    typedef struct packed {
        logic        fan_one;
        logic        fan_two;
        reason_t     reason;
        logic [31:0] last_change;
        logic        override_active;
    } ctl_state_t;

endpackage

[rtl/tfatc_eval.sv]
// ----------------------------------------------------------------------------
// tfatc_eval
// Decision logic: next controller state and change flag for one transaction.
// ----------------------------------------------------------------------------
module tfatc_eval
    import tfatc_pkg::*;
(
    input  cfg_t       cfg,
    input  item_t      item,
    input  ctl_state_t state_cur,
    output ctl_state_t state_next,
    output logic       changed
);

    logic [31:0] elapsed;
    logic        locked;
    logic        want_one;
    logic        want_two;
    reason_t     why;
    logic        hold;
    logic        clear_ok;

    // wrapping elapsed time and lockout
    assign elapsed  = item.now_ms - state_cur.last_change;
    assign locked   = (elapsed < cfg.min_cycle_ms) && (state_cur.last_change != 32'd0);
    assign clear_ok = ($signed(item.temperature) <= $signed(cfg.temp_clear)) &&
                      (item.humidity <= cfg.humid_clear) &&
                      (item.vpd >= cfg.vpd_ok);

    // priority rules
    always_comb begin
        want_one = 1'b0;
        want_two = 1'b0;
        why      = RSN_NONE;
        hold     = 1'b0;
        if ($signed(item.temperature) >= $signed(cfg.temp_extreme)) begin
            want_one = 1'b1;
            want_two = 1'b1;
            why      = RSN_TEMP;
        end else if (item.humidity >= cfg.humid_high) begin
            want_one = 1'b1;
            want_two = 1'b1;
            why      = RSN_HUMID;
        end else if (item.vpd < cfg.vpd_low) begin
            want_one = 1'b1;
            why      = RSN_VPD;
        end else if ($signed(item.temperature) > $signed(cfg.temp_stage_one)) begin
            want_one = 1'b1;
            why      = RSN_TEMP;
        end else if (state_cur.fan_one || state_cur.fan_two) begin
            hold = !clear_ok;
        end
    end

    // state update
    always_comb begin
        state_next = state_cur;
        changed    = 1'b0;
        if (item.mode == MODE_OVERRIDE) begin
            state_next.override_active = item.override_enable;
            if (item.override_enable) begin
                state_next.reason  = RSN_MANUAL;
                state_next.fan_one = item.override_fan_one;
                state_next.fan_two = item.override_fan_two;
                changed            = 1'b1;
            end
        end else if (!state_cur.override_active && !locked && !hold &&
                     ((want_one != state_cur.fan_one) || (want_two != state_cur.fan_two))) begin
            state_next.fan_one     = want_one;
            state_next.fan_two     = want_two;
            state_next.reason      = why;
            state_next.last_change = item.now_ms;
            changed                = 1'b1;
        end
    end

endmodule

[rtl/two_fan_airflow_threshold_controller_core.sv]
// ----------------------------------------------------------------------------
// two_fan_airflow_threshold_controller_core
// Two-fan relay controller with hysteresis, lockout and manual override.
// ----------------------------------------------------------------------------
// Path: input acceptance into the input register, then decision logic into
//   the result register.
// Throughput: one transaction per cycle unless m_ready stalls; the decision
//   stage updates state and loads the result register in the same cycle.
// Reset: synchronous active-low aresetn clears fan states, reason, change
//   stamp, override and both valid flags, and loads the threshold defaults.
module two_fan_airflow_threshold_controller_core
    import tfatc_pkg::*;
#(
    parameter bit FAN_ONE_ACTIVE_LOW = 1'b0,
    parameter bit FAN_TWO_ACTIVE_LOW = 1'b0
)
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [14:0] s_temperature,
    input  logic [13:0] s_humidity,
    input  logic [13:0] s_vpd,
    input  logic [31:0] s_now_ms,
    input  logic        s_override_enable,
    input  logic        s_override_fan_one,
    input  logic        s_override_fan_two,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_fan_one_on,
    output logic        m_fan_two_on,
    output logic        m_pin_one_level,
    output logic        m_pin_two_level,
    output logic [2:0]  m_trigger_reason,
    output logic        m_outputs_changed
);

    cfg_t       cfg_reg;
    item_t      item_reg;
    logic       item_valid_reg;
    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       changed_next;
    logic       out_valid_reg;
    logic       out_fan_one_reg;
    logic       out_fan_two_reg;
    reason_t    out_reason_reg;
    logic       out_changed_reg;
    logic       advance;

    // handshake: decision stage moves when the result register is free or drains
    assign advance = item_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !item_valid_reg || advance;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.temp_extreme   <= TEMP_EXTREME_RST;
            cfg_reg.temp_stage_one <= TEMP_STAGE_ONE_RST;
            cfg_reg.temp_clear     <= TEMP_CLEAR_RST;
            cfg_reg.humid_high     <= HUMID_HIGH_RST;
            cfg_reg.humid_clear    <= HUMID_CLEAR_RST;
            cfg_reg.vpd_low        <= VPD_LOW_RST;
            cfg_reg.vpd_ok         <= VPD_OK_RST;
            cfg_reg.min_cycle_ms   <= MIN_CYCLE_MS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TEMP_EXTREME:   cfg_reg.temp_extreme   <= cfg_wdata[14:0];
                CFG_TEMP_STAGE_ONE: cfg_reg.temp_stage_one <= cfg_wdata[14:0];
                CFG_TEMP_CLEAR:     cfg_reg.temp_clear     <= cfg_wdata[14:0];
                CFG_HUMID_HIGH:     cfg_reg.humid_high     <= cfg_wdata[13:0];
                CFG_HUMID_CLEAR:    cfg_reg.humid_clear    <= cfg_wdata[13:0];
                CFG_VPD_LOW:        cfg_reg.vpd_low        <= cfg_wdata[13:0];
                CFG_VPD_OK:         cfg_reg.vpd_ok         <= cfg_wdata[13:0];
                CFG_MIN_CYCLE_MS:   cfg_reg.min_cycle_ms   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_ready) begin
            item_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.mode             <= s_mode;
            item_reg.temperature      <= s_temperature;
            item_reg.humidity         <= s_humidity;
            item_reg.vpd              <= s_vpd;
            item_reg.now_ms           <= s_now_ms;
            item_reg.override_enable  <= s_override_enable;
            item_reg.override_fan_one <= s_override_fan_one;
            item_reg.override_fan_two <= s_override_fan_two;
        end
    end

    // decision logic
    tfatc_eval u_eval (
        .cfg        (cfg_reg),
        .item       (item_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .changed    (changed_next)
    );

    // controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.fan_one         <= 1'b0;
            state_reg.fan_two         <= 1'b0;
            state_reg.reason          <= RSN_NONE;
            state_reg.last_change     <= 32'd0;
            state_reg.override_active <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_fan_one_reg <= state_next.fan_one;
            out_fan_two_reg <= state_next.fan_two;
            out_reason_reg  <= state_next.reason;
            out_changed_reg <= changed_next;
        end
    end

    // result outputs
    assign m_valid           = out_valid_reg;
    assign m_fan_one_on      = out_fan_one_reg;
    assign m_fan_two_on      = out_fan_two_reg;
    assign m_pin_one_level   = out_fan_one_reg ^ FAN_ONE_ACTIVE_LOW;
    assign m_pin_two_level   = out_fan_two_reg ^ FAN_TWO_ACTIVE_LOW;
    assign m_trigger_reason  = out_reason_reg;
    assign m_outputs_changed = out_changed_reg;

    // state holds while a result waits for the consumer
    a_state_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(state_reg))
        else $error("controller state changed while result stalled");

    // an active override freezes the fans against sensor transactions
    a_override_freezes_fans: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && state_reg.override_active && (item_reg.mode == MODE_EVAL))
        |=> ($stable(state_reg.fan_one) && $stable(state_reg.fan_two) && !m_outputs_changed))
        else $error("sensor transaction changed fans under override");

    // sensor-driven change stamps the change time
    a_change_stamps_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && changed_next && (item_reg.mode == MODE_EVAL))
        |=> (state_reg.last_change == $past(item_reg.now_ms)))
        else $error("applied change did not stamp the change time");

    // no result straight out of reset
    a_reset_no_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule
